// File: src/ph_ec_dosing_controller_defines.svh
// assertion macros for the ph/ec dosing controller
// used by the top level only, no other dependencies
`ifndef PH_EC_DOSING_CONTROLLER_DEFINES_SVH
`define PH_EC_DOSING_CONTROLLER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PHEC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PHEC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/phec_pkg.sv
// shared types, codes and constants of the ph/ec dosing controller
// no dependencies
`timescale 1ns / 1ps

package phec_pkg;

    localparam int PH_W   = 11;
    localparam int EC_W   = 13;
    localparam int IDX_W  = 3;
    localparam int DATA_W = 13;

    localparam int TICK_WIDTH_DEF = 16;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_MEASURE = 2'd1,
        OP_PROCESS = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        IND_LOW  = 2'd0,
        IND_OPT  = 2'd1,
        IND_HIGH = 2'd2
    } ind_t;

    // register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_PH_VALID_MIN  = 3'd0,
        REG_PH_VALID_MAX  = 3'd1,
        REG_PH_LOW_LEVEL  = 3'd2,
        REG_PH_HIGH_LEVEL = 3'd3,
        REG_EC_VALID_MIN  = 3'd4,
        REG_EC_VALID_MAX  = 3'd5,
        REG_EC_LOW_LEVEL  = 3'd6,
        REG_EC_HIGH_LEVEL = 3'd7
    } reg_idx_t;

    localparam logic [PH_W-1:0] PH_VALID_MIN_RST  = 11'd0;
    localparam logic [PH_W-1:0] PH_VALID_MAX_RST  = 11'd1400;
    localparam logic [PH_W-1:0] PH_LOW_LEVEL_RST  = 11'd550;
    localparam logic [PH_W-1:0] PH_HIGH_LEVEL_RST = 11'd650;
    localparam logic [EC_W-1:0] EC_VALID_MIN_RST  = 13'd0;
    localparam logic [EC_W-1:0] EC_VALID_MAX_RST  = 13'd8191;
    localparam logic [EC_W-1:0] EC_LOW_LEVEL_RST  = 13'd800;
    localparam logic [EC_W-1:0] EC_HIGH_LEVEL_RST = 13'd1500;

    // pump schedule on the tick timers
    localparam int PULSE_ON_LO  = 10;
    localparam int PULSE_ON_HI  = 12;
    localparam int PULSE_OFF_LO = 15;
    localparam int PULSE_OFF_HI = 17;

    // flag and pump bit positions
    localparam int B_PH_LOW  = 0;
    localparam int B_PH_HIGH = 1;
    localparam int B_EC_LOW  = 2;
    localparam int B_EC_HIGH = 3;

    typedef struct packed {
        logic [PH_W-1:0] ph_valid_min;
        logic [PH_W-1:0] ph_valid_max;
        logic [PH_W-1:0] ph_low_level;
        logic [PH_W-1:0] ph_high_level;
        logic [EC_W-1:0] ec_valid_min;
        logic [EC_W-1:0] ec_valid_max;
        logic [EC_W-1:0] ec_low_level;
        logic [EC_W-1:0] ec_high_level;
    } cfg_t;

    typedef struct packed {
        ind_t       ph_ind;
        ind_t       ec_ind;
        logic [3:0] pumps;
        logic [3:0] flags;
    } status_t;

    function automatic ind_t classify(input logic [EC_W-1:0] v,
                                      input logic [EC_W-1:0] lo,
                                      input logic [EC_W-1:0] hi);
        ind_t r;
        if (v <= lo) begin
            r = IND_LOW;
        end else if (v >= hi) begin
            r = IND_HIGH;
        end else begin
            r = IND_OPT;
        end
        return r;
    endfunction

    function automatic logic ph_low_band(input logic [PH_W-1:0] d);
        return (d >= 11'd10  && d <= 11'd200) || (d >= 11'd210 && d <= 11'd250) ||
               (d >= 11'd260 && d <= 11'd350) || (d >= 11'd360 && d <= 11'd450);
    endfunction

    function automatic logic ph_high_band(input logic [PH_W-1:0] d);
        return (d >= 11'd10  && d <= 11'd50)  || (d >= 11'd60 && d <= 11'd100) ||
               (d >= 11'd110 && d <= 11'd150) || (d >= 11'd160 && d <= 11'd700);
    endfunction

    localparam logic [EC_W-1:0] EC_LOW_BAND_MAX  = 13'd800;
    localparam logic [EC_W-1:0] EC_HIGH_BAND_MAX = 13'd500;

endpackage

// File: src/phec_cfg_regs.sv
// configuration register file, eight threshold registers
// depends on phec_pkg
`timescale 1ns / 1ps

module phec_cfg_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [phec_pkg::IDX_W-1:0]  wr_addr,
    input  logic [phec_pkg::DATA_W-1:0] wr_data,
    output phec_pkg::cfg_t              cfg
);
    import phec_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx_t'(wr_addr))
                REG_PH_VALID_MIN:  cfg_next.ph_valid_min  = wr_data[PH_W-1:0];
                REG_PH_VALID_MAX:  cfg_next.ph_valid_max  = wr_data[PH_W-1:0];
                REG_PH_LOW_LEVEL:  cfg_next.ph_low_level  = wr_data[PH_W-1:0];
                REG_PH_HIGH_LEVEL: cfg_next.ph_high_level = wr_data[PH_W-1:0];
                REG_EC_VALID_MIN:  cfg_next.ec_valid_min  = wr_data[EC_W-1:0];
                REG_EC_VALID_MAX:  cfg_next.ec_valid_max  = wr_data[EC_W-1:0];
                REG_EC_LOW_LEVEL:  cfg_next.ec_low_level  = wr_data[EC_W-1:0];
                REG_EC_HIGH_LEVEL: cfg_next.ec_high_level = wr_data[EC_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ph_valid_min  <= PH_VALID_MIN_RST;
            cfg_reg.ph_valid_max  <= PH_VALID_MAX_RST;
            cfg_reg.ph_low_level  <= PH_LOW_LEVEL_RST;
            cfg_reg.ph_high_level <= PH_HIGH_LEVEL_RST;
            cfg_reg.ec_valid_min  <= EC_VALID_MIN_RST;
            cfg_reg.ec_valid_max  <= EC_VALID_MAX_RST;
            cfg_reg.ec_low_level  <= EC_LOW_LEVEL_RST;
            cfg_reg.ec_high_level <= EC_HIGH_LEVEL_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/phec_core.sv
// controller state: timers, latched readings, valid marks, dosing flags, pumps
// and indicators, with the per-request update logic; depends on phec_pkg
`timescale 1ns / 1ps

module phec_core #(
    parameter int TICK_WIDTH = phec_pkg::TICK_WIDTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      step,
    input  phec_pkg::op_t             op,
    input  logic [phec_pkg::PH_W-1:0] ph_reading,
    input  logic [phec_pkg::EC_W-1:0] ec_reading,
    input  phec_pkg::cfg_t            cfg,
    output phec_pkg::status_t         status_next
);
    import phec_pkg::*;

    logic [TICK_WIDTH-1:0] ph_tick_reg, ph_tick_next;
    logic [TICK_WIDTH-1:0] ec_tick_reg, ec_tick_next;
    logic [PH_W-1:0]       ph_latched_reg, ph_latched_next;
    logic [EC_W-1:0]       ec_latched_reg, ec_latched_next;
    logic [1:0]            marks_reg, marks_next;
    logic [3:0]            flags_reg, flags_next;
    logic [3:0]            pumps_reg, pumps_next;
    ind_t                  ph_ind_reg, ph_ind_next;
    ind_t                  ec_ind_reg, ec_ind_next;

    logic [PH_W-1:0] ph_low_diff, ph_high_diff;
    logic [EC_W-1:0] ec_low_diff, ec_high_diff;
    logic [3:0]      keep;
    logic            ph_on_win, ph_off_win, ec_on_win, ec_off_win;
    logic [3:0]      on_win, off_win;

    // deviations, only meaningful where the sign test passes
    assign ph_low_diff  = cfg.ph_low_level - ph_latched_reg;
    assign ph_high_diff = ph_latched_reg - cfg.ph_high_level;
    assign ec_low_diff  = cfg.ec_low_level - ec_latched_reg;
    assign ec_high_diff = ec_latched_reg - cfg.ec_high_level;

    assign keep[B_PH_LOW]  = (cfg.ph_low_level >= ph_latched_reg) && ph_low_band(ph_low_diff);
    assign keep[B_PH_HIGH] = (ph_latched_reg >= cfg.ph_high_level) && ph_high_band(ph_high_diff);
    assign keep[B_EC_LOW]  = (cfg.ec_low_level >= ec_latched_reg) &&
                             (ec_low_diff <= EC_LOW_BAND_MAX);
    assign keep[B_EC_HIGH] = (ec_latched_reg >= cfg.ec_high_level) &&
                             (ec_high_diff <= EC_HIGH_BAND_MAX);

    assign ph_on_win  = (ph_tick_reg >= TICK_WIDTH'(PULSE_ON_LO)) &&
                        (ph_tick_reg <= TICK_WIDTH'(PULSE_ON_HI));
    assign ph_off_win = (ph_tick_reg >= TICK_WIDTH'(PULSE_OFF_LO)) &&
                        (ph_tick_reg <= TICK_WIDTH'(PULSE_OFF_HI));
    assign ec_on_win  = (ec_tick_reg >= TICK_WIDTH'(PULSE_ON_LO)) &&
                        (ec_tick_reg <= TICK_WIDTH'(PULSE_ON_HI));
    assign ec_off_win = (ec_tick_reg >= TICK_WIDTH'(PULSE_OFF_LO)) &&
                        (ec_tick_reg <= TICK_WIDTH'(PULSE_OFF_HI));

    assign on_win  = {ec_on_win, ec_on_win, ph_on_win, ph_on_win};
    assign off_win = {ec_off_win, ec_off_win, ph_off_win, ph_off_win};

    always_comb begin
        ph_tick_next    = ph_tick_reg;
        ec_tick_next    = ec_tick_reg;
        ph_latched_next = ph_latched_reg;
        ec_latched_next = ec_latched_reg;
        marks_next      = marks_reg;
        flags_next      = flags_reg;
        pumps_next      = pumps_reg;
        ph_ind_next     = ph_ind_reg;
        ec_ind_next     = ec_ind_reg;
        case (op)
            OP_TICK: begin
                if (ph_tick_reg != {TICK_WIDTH{1'b1}}) begin
                    ph_tick_next = ph_tick_reg + 1'b1;
                end
                if (ec_tick_reg != {TICK_WIDTH{1'b1}}) begin
                    ec_tick_next = ec_tick_reg + 1'b1;
                end
            end
            OP_MEASURE: begin
                ph_latched_next = ph_reading;
                ec_latched_next = ec_reading;
                if (ph_reading > cfg.ph_valid_min && ph_reading < cfg.ph_valid_max) begin
                    marks_next[0] = 1'b1;
                end
                if (ec_reading > cfg.ec_valid_min && ec_reading < cfg.ec_valid_max) begin
                    marks_next[1] = 1'b1;
                end
                if (marks_next[0]) begin
                    ph_ind_next = classify(EC_W'(ph_reading), EC_W'(cfg.ph_low_level),
                                           EC_W'(cfg.ph_high_level));
                    if (ph_ind_next == IND_LOW) begin
                        flags_next[B_PH_LOW] = 1'b1;
                    end else if (ph_ind_next == IND_HIGH) begin
                        flags_next[B_PH_HIGH] = 1'b1;
                    end
                end
                if (marks_next[1]) begin
                    ec_ind_next = classify(ec_reading, cfg.ec_low_level, cfg.ec_high_level);
                    if (ec_ind_next == IND_LOW) begin
                        flags_next[B_EC_LOW] = 1'b1;
                    end else if (ec_ind_next == IND_HIGH) begin
                        flags_next[B_EC_HIGH] = 1'b1;
                    end
                end
            end
            OP_PROCESS: begin
                for (int b = 0; b < 4; b++) begin
                    if (flags_reg[b]) begin
                        if (!keep[b]) begin
                            flags_next[b] = 1'b0;
                        end else if (on_win[b]) begin
                            pumps_next[b] = 1'b1;
                        end else if (off_win[b]) begin
                            pumps_next[b] = 1'b0;
                            flags_next[b] = 1'b0;
                        end
                    end
                end
            end
            OP_CLEAR: begin
                ph_tick_next = '0;
                ec_tick_next = '0;
            end
            default: begin
                ph_tick_next = ph_tick_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_tick_reg    <= '0;
            ec_tick_reg    <= '0;
            ph_latched_reg <= '0;
            ec_latched_reg <= '0;
            marks_reg      <= '0;
            flags_reg      <= '0;
            pumps_reg      <= '0;
            ph_ind_reg     <= IND_OPT;
            ec_ind_reg     <= IND_OPT;
        end else if (step) begin
            ph_tick_reg    <= ph_tick_next;
            ec_tick_reg    <= ec_tick_next;
            ph_latched_reg <= ph_latched_next;
            ec_latched_reg <= ec_latched_next;
            marks_reg      <= marks_next;
            flags_reg      <= flags_next;
            pumps_reg      <= pumps_next;
            ph_ind_reg     <= ph_ind_next;
            ec_ind_reg     <= ec_ind_next;
        end
    end

    assign status_next.ph_ind = ph_ind_next;
    assign status_next.ec_ind = ec_ind_next;
    assign status_next.pumps  = pumps_next;
    assign status_next.flags  = flags_next;

endmodule

// File: src/ph_ec_dosing_controller.sv
// channel   | handshake          | payload
// s_ (in)   | s_valid / s_ready  | s_operation, s_ph_reading, s_ec_reading
// m_ (out)  | m_valid / m_ready  | indicators, pump states, pending flags, dosing_done
// cfg (reg) | cfg_valid/cfg_ready| cfg_addr, cfg_wdata
//
// one request per cycle sustained while m_ready keeps up; a result is presented once its request
// has passed the input register, then the state update into the result register
// cfg_ready is always high, a register write takes effect on the next edge
// aresetn is synchronous: timers, marks and flags clear, pumps off, indicators optimum
// a stalled result holds the input register; s_ready drops only when both are full
// depends on phec_pkg, phec_cfg_regs, phec_core and ph_ec_dosing_controller_defines.svh
`timescale 1ns / 1ps
`include "ph_ec_dosing_controller_defines.svh"

module ph_ec_dosing_controller #(
    parameter int TICK_WIDTH = phec_pkg::TICK_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_operation,
    input  logic [phec_pkg::PH_W-1:0]   s_ph_reading,
    input  logic [phec_pkg::EC_W-1:0]   s_ec_reading,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_ph_indicator,
    output logic [1:0]                  m_ec_indicator,
    output logic                        m_ph_raise_pump,
    output logic                        m_ph_lower_pump,
    output logic                        m_ec_raise_pumps,
    output logic                        m_ec_lower_pump,
    output logic                        m_ph_low_pending,
    output logic                        m_ph_high_pending,
    output logic                        m_ec_low_pending,
    output logic                        m_ec_high_pending,
    output logic                        m_dosing_done,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [phec_pkg::IDX_W-1:0]  cfg_addr,
    input  logic [phec_pkg::DATA_W-1:0] cfg_wdata
);
    import phec_pkg::*;

    cfg_t            cfg;
    status_t         status_next;
    status_t         out_reg;
    logic            in_valid_reg, in_valid_next;
    logic            m_valid_reg, m_valid_next;
    op_t             op_reg;
    logic [PH_W-1:0] ph_reg;
    logic [EC_W-1:0] ec_reg;
    logic            advance;
    logic            s_fire;

    assign cfg_ready = 1'b1;

    phec_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (cfg_valid),
        .wr_addr (cfg_addr),
        .wr_data (cfg_wdata),
        .cfg     (cfg)
    );

    // the request in the input register moves on when the result slot is free or is being taken
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        in_valid_next = (in_valid_reg && !advance) || s_fire;
        m_valid_next  = (m_valid_reg && !m_ready) || advance;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg <= op_t'(s_operation);
            ph_reg <= s_ph_reading;
            ec_reg <= s_ec_reading;
        end
        if (advance) begin
            out_reg <= status_next;
        end
    end

    phec_core #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .op          (op_reg),
        .ph_reading  (ph_reg),
        .ec_reading  (ec_reg),
        .cfg         (cfg),
        .status_next (status_next)
    );

    assign m_valid           = m_valid_reg;
    assign m_ph_indicator    = out_reg.ph_ind;
    assign m_ec_indicator    = out_reg.ec_ind;
    assign m_ph_raise_pump   = out_reg.pumps[B_PH_LOW];
    assign m_ph_lower_pump   = out_reg.pumps[B_PH_HIGH];
    assign m_ec_raise_pumps  = out_reg.pumps[B_EC_LOW];
    assign m_ec_lower_pump   = out_reg.pumps[B_EC_HIGH];
    assign m_ph_low_pending  = out_reg.flags[B_PH_LOW];
    assign m_ph_high_pending = out_reg.flags[B_PH_HIGH];
    assign m_ec_low_pending  = out_reg.flags[B_EC_LOW];
    assign m_ec_high_pending = out_reg.flags[B_EC_HIGH];
    assign m_dosing_done     = ~|out_reg.flags;

    `PHEC_ASSERT_NEXT(a_in_hold, aclk, aresetn, in_valid_reg && !advance, in_valid_reg && $stable(op_reg), "stalled request left the input register")
    `PHEC_ASSERT_SAME(a_refill_moves, aclk, aresetn, s_fire && in_valid_reg, advance, "input register overwritten before its request moved on")
    `PHEC_ASSERT_NEXT(a_result_loaded, aclk, aresetn, advance, m_valid_reg, "request moved on but no result was presented")
    `PHEC_ASSERT_SAME(a_done_flags, aclk, aresetn, m_valid_reg && m_dosing_done, !m_ph_low_pending && !m_ph_high_pending && !m_ec_low_pending && !m_ec_high_pending, "dosing reported done with a request still pending")

endmodule
